FILE: rtl/spf_pkg.sv
package spf_pkg;

    localparam int MAX_NODES_DEFAULT   = 16;
    localparam int WEIGHT_BITS_DEFAULT = 16;

    localparam logic [4:0] NODE_COUNT_RESET = 5'd16;
    localparam logic [2:0] ADDR_NODE_COUNT  = 3'd0;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_RUN   = 1'b1;

    localparam logic [1:0] STATUS_ARC     = 2'd0;
    localparam logic [1:0] STATUS_SINGLE  = 2'd1;
    localparam logic [1:0] STATUS_UNREACH = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_SINGLE,
        ST_UNREACH
    } state_t;

    typedef struct packed {
        logic       store;
        logic       run_init;
        logic       mark;
        logic       scan_issue;
        logic       pick;
        logic       emit_start;
        logic       emit_load;
        logic       stat_load;
        logic [1:0] stat_code;
        logic       clear;
    } cmd_t;

    typedef struct packed {
        logic sel_is_tgt;
        logic tgt_zero;
        logic scan_last;
        logic have;
        logic out_free;
        logic pred_zero;
        logic clr_last;
    } sts_t;

endpackage

FILE: rtl/spf_ram.sv
module spf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/spf_ctrl.sv
module spf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           s_tuser,
    output logic           s_tready,
    input  spf_pkg::sts_t  sts,
    output spf_pkg::cmd_t  cmd
);

    spf_pkg::state_t state_reg;
    spf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spf_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.stat_code = spf_pkg::STATUS_ARC;
        s_tready      = 1'b0;
        case (state_reg)
            spf_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = spf_pkg::ST_IDLE;
                end
            end
            spf_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == spf_pkg::OP_RUN)
                    begin
                        cmd.run_init = 1'b1;
                        state_next   = spf_pkg::ST_MARK;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            spf_pkg::ST_MARK:
            begin
                cmd.mark = 1'b1;
                if (sts.sel_is_tgt)
                begin
                    if (sts.tgt_zero)
                    begin
                        state_next = spf_pkg::ST_SINGLE;
                    end
                    else
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = spf_pkg::ST_EMIT_RD;
                    end
                end
                else
                begin
                    state_next = spf_pkg::ST_SCAN;
                end
            end
            spf_pkg::ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = spf_pkg::ST_DRAIN;
                end
            end
            spf_pkg::ST_DRAIN:
            begin
                state_next = spf_pkg::ST_PICK;
            end
            spf_pkg::ST_PICK:
            begin
                if (sts.have)
                begin
                    cmd.pick   = 1'b1;
                    state_next = spf_pkg::ST_MARK;
                end
                else
                begin
                    state_next = spf_pkg::ST_UNREACH;
                end
            end
            spf_pkg::ST_EMIT_RD:
            begin
                state_next = spf_pkg::ST_EMIT_LD;
            end
            spf_pkg::ST_EMIT_LD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = sts.pred_zero ? spf_pkg::ST_CLEAR : spf_pkg::ST_EMIT_RD;
                end
            end
            spf_pkg::ST_SINGLE:
            begin
                if (sts.out_free)
                begin
                    cmd.stat_load = 1'b1;
                    cmd.stat_code = spf_pkg::STATUS_SINGLE;
                    state_next    = spf_pkg::ST_CLEAR;
                end
            end
            spf_pkg::ST_UNREACH:
            begin
                if (sts.out_free)
                begin
                    cmd.stat_load = 1'b1;
                    cmd.stat_code = spf_pkg::STATUS_UNREACH;
                    state_next    = spf_pkg::ST_CLEAR;
                end
            end
            default:
            begin
                state_next = spf_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: rtl/spf_dp.sv
module spf_dp #(
    parameter int MAX_NODES   = spf_pkg::MAX_NODES_DEFAULT,
    parameter int WEIGHT_BITS = spf_pkg::WEIGHT_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  spf_pkg::cmd_t cmd,
    output spf_pkg::sts_t sts,
    input  logic [4:0]    node_count,
    input  logic [3:0]    arc_source,
    input  logic [3:0]    arc_target,
    input  logic [15:0]   arc_weight,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);

    localparam int NB     = $clog2(MAX_NODES);
    localparam int WB     = WEIGHT_BITS;
    localparam int DB     = WB + NB;
    localparam int AB     = 2 * NB;
    localparam int WDEPTH = 1 << AB;

    logic [NB-1:0]        tgt_reg, tgt_next;
    logic [NB-1:0]        sel_reg, sel_next;
    logic [DB-1:0]        dsel_reg, dsel_next;
    logic [MAX_NODES-1:0] reached_reg, reached_next;
    logic [MAX_NODES-1:0] done_reg, done_next;
    logic [NB-1:0]        idx_reg, idx_next;
    logic                 v1_reg, v1_next;
    logic [NB-1:0]        i1_reg, i1_next;
    logic                 have_reg, have_next;
    logic [NB-1:0]        best_reg, best_next;
    logic [DB-1:0]        bestd_reg, bestd_next;
    logic [AB-1:0]        clr_reg, clr_next;
    logic [NB-1:0]        cur_reg, cur_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [3:0]           out_from_reg, out_from_next;
    logic [3:0]           out_to_reg, out_to_next;
    logic                 out_last_reg, out_last_next;

    logic          w_we;
    logic [AB-1:0] w_waddr;
    logic [WB-1:0] w_wdata;
    logic [WB-1:0] w_rdata;
    logic [DB-1:0] dist_rdata;
    logic [NB-1:0] pred_rdata;
    logic          relax_we;
    logic [DB-1:0] d_sum;
    logic          cand;
    logic [DB-1:0] cand_val;
    logic          arc_ok;
    logic          out_free;

    assign arc_ok = (32'(arc_source) < MAX_NODES) && (32'(arc_target) < MAX_NODES);
    assign w_we    = cmd.clear || (cmd.store && arc_ok);
    assign w_waddr = cmd.clear ? clr_reg : {NB'(arc_source), NB'(arc_target)};
    assign w_wdata = cmd.clear ? '0 : WB'(arc_weight);

    spf_ram #(.WIDTH(WB), .DEPTH(WDEPTH)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr ({sel_reg, idx_reg}),
        .rdata (w_rdata)
    );

    spf_ram #(.WIDTH(DB), .DEPTH(MAX_NODES)) u_dist_ram (
        .clk   (clk),
        .we    (relax_we),
        .waddr (i1_reg),
        .wdata (d_sum),
        .raddr (idx_reg),
        .rdata (dist_rdata)
    );

    spf_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_pred_ram (
        .clk   (clk),
        .we    (relax_we),
        .waddr (i1_reg),
        .wdata (sel_reg),
        .raddr (cur_reg),
        .rdata (pred_rdata)
    );

    // relax stage: weight and distance of node i1 arrive together
    always_comb
    begin
        d_sum    = dsel_reg + DB'(w_rdata);
        relax_we = v1_reg && (w_rdata != '0) && !done_reg[i1_reg]
                   && (!reached_reg[i1_reg] || (d_sum < dist_rdata));
        cand     = v1_reg && !done_reg[i1_reg] && (reached_reg[i1_reg] || relax_we);
        cand_val = relax_we ? d_sum : dist_rdata;
    end

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        tgt_next        = tgt_reg;
        sel_next        = sel_reg;
        dsel_next       = dsel_reg;
        reached_next    = reached_reg;
        done_next       = done_reg;
        idx_next        = idx_reg;
        v1_next         = cmd.scan_issue;
        i1_next         = idx_reg;
        have_next       = have_reg;
        best_next       = best_reg;
        bestd_next      = bestd_reg;
        clr_next        = clr_reg;
        cur_next        = cur_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_from_next   = out_from_reg;
        out_to_next     = out_to_reg;
        out_last_next   = out_last_reg;

        if (cmd.run_init)
        begin
            if (node_count == 5'd0)
            begin
                tgt_next = '0;
            end
            else if (32'(node_count) > MAX_NODES)
            begin
                tgt_next = NB'(MAX_NODES - 1);
            end
            else
            begin
                tgt_next = NB'(node_count - 5'd1);
            end
            sel_next        = '0;
            dsel_next       = '0;
            reached_next    = '0;
            reached_next[0] = 1'b1;
            done_next       = '0;
        end

        if (cmd.mark)
        begin
            done_next[sel_reg] = 1'b1;
            idx_next           = '0;
            have_next          = 1'b0;
        end

        if (cmd.scan_issue)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (relax_we)
        begin
            reached_next[i1_reg] = 1'b1;
        end

        if (cand && (!have_reg || (cand_val < bestd_reg)))
        begin
            have_next  = 1'b1;
            best_next  = i1_reg;
            bestd_next = cand_val;
        end

        if (cmd.pick)
        begin
            sel_next  = best_reg;
            dsel_next = bestd_reg;
        end

        if (cmd.emit_start)
        begin
            cur_next = tgt_reg;
        end

        if (cmd.emit_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = spf_pkg::STATUS_ARC;
            out_from_next   = 4'(cur_reg);
            out_to_next     = 4'(pred_rdata);
            out_last_next   = (pred_rdata == '0);
            cur_next        = pred_rdata;
        end

        if (cmd.stat_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = cmd.stat_code;
            out_from_next   = '0;
            out_to_next     = '0;
            out_last_next   = 1'b1;
        end

        if (cmd.clear)
        begin
            clr_next = clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reached_reg   <= '0;
            done_reg      <= '0;
            v1_reg        <= 1'b0;
            have_reg      <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            reached_reg   <= reached_next;
            done_reg      <= done_next;
            v1_reg        <= v1_next;
            have_reg      <= have_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg        <= tgt_next;
        sel_reg        <= sel_next;
        dsel_reg       <= dsel_next;
        idx_reg        <= idx_next;
        i1_reg         <= i1_next;
        best_reg       <= best_next;
        bestd_reg      <= bestd_next;
        cur_reg        <= cur_next;
        out_status_reg <= out_status_next;
        out_from_reg   <= out_from_next;
        out_to_reg     <= out_to_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        sts.sel_is_tgt = (sel_reg == tgt_reg);
        sts.tgt_zero   = (tgt_reg == '0);
        sts.scan_last  = (idx_reg == tgt_reg);
        sts.have       = have_reg;
        sts.out_free   = out_free;
        sts.pred_zero  = (pred_rdata == '0);
        sts.clr_last   = &clr_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_to_reg, out_from_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    a_done_implies_reached: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg & ~reached_reg) == '0)
        else $error("node finished without being reached");

    a_no_store_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_issue || v1_reg) |-> !cmd.store)
        else $error("arc store during relax scan");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_load || cmd.stat_load) |-> out_free)
        else $error("output register overwritten before transfer");

    a_pick_needs_candidate: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick |-> have_reg)
        else $error("pick without a candidate node");

endmodule

FILE: rtl/shortest_path_first_to_last_unit.sv
// Shortest path from node 0 to node node_count-1 over a directed weight matrix.
// Arc stores (tuser = 0) are taken one per cycle while idle. A run (tuser = 1)
// holds off input while the search walks the matrix: each selected node is
// marked, its row is scanned over nodes 0 to the target, the scan drains and
// the nearest reached open node is picked; then each path arc is read and sent,
// waiting while the output stalls. The path comes out from the target back toward
// node 0 as (node, predecessor) pairs, or as one status transfer for a single
// node or an unreachable target; tlast marks the final transfer of a run.
// After every run, and once after reset, the matrix is swept clear one entry
// per cycle, all 2**(2*clog2(MAX_NODES)) entries (256 at 16 nodes), during
// which no item is accepted. Register writes are accepted at any time but must
// only be issued while the block is idle.
module shortest_path_first_to_last_unit #(
    parameter int MAX_NODES   = spf_pkg::MAX_NODES_DEFAULT,
    parameter int WEIGHT_BITS = spf_pkg::WEIGHT_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // arc_source[3:0], arc_target[7:4], arc_weight[23:8]
    input  logic        s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // path_from[3:0], path_to[7:4]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);

    logic [4:0]    node_count_reg;
    logic [4:0]    node_count_next;
    spf_pkg::cmd_t cmd;
    spf_pkg::sts_t sts;

    assign pready = 1'b1;

    always_comb
    begin
        node_count_next = node_count_reg;
        if (psel && penable && pwrite && pready && (paddr == spf_pkg::ADDR_NODE_COUNT))
        begin
            node_count_next = pwdata[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= spf_pkg::NODE_COUNT_RESET;
        end
        else
        begin
            node_count_reg <= node_count_next;
        end
    end

    assign prdata = (paddr == spf_pkg::ADDR_NODE_COUNT) ? 32'(node_count_reg) : '0;

    spf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spf_dp #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .node_count (node_count_reg),
        .arc_source (s_tdata[3:0]),
        .arc_target (s_tdata[7:4]),
        .arc_weight (s_tdata[23:8]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
